[hdl/siu_pkg.sv]
// siu_pkg: shared types and constants for the set intersection unit
// no dependencies; imported by siu_ram and set_intersection_unique_unit
`default_nettype none

package siu_pkg;

  // element width, fixed by the transaction format
  localparam int ITEM_W = 32;

  // default number of entries in each store
  localparam int STORE_DEPTH_DEF = 256;

  // operation codes carried on func
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_PROBE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_REF,
    ST_SCAN_EMIT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[hdl/siu_ram.sv]
// siu_ram: single write port, single read port store with registered read data
// depends on siu_pkg for the default depth and data width
`default_nettype none

module siu_ram #(
  parameter int DEPTH  = siu_pkg::STORE_DEPTH_DEF,
  parameter int ADDR_W = 8,
  parameter int DATA_W = siu_pkg::ITEM_W
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);
  import siu_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/set_intersection_unique_unit.sv]
// set_intersection_unique_unit: distinct intersection of two integer lists
// depends on siu_pkg and siu_ram (reference store and emitted store)
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | into unit | in_valid/in_stall  | func, item
//  out     | from unit | out_valid/out_stall| emitted, item_out, store_full
//
// scan: a probe walks the reference store and, if the value is found there,
//   the emitted store, up to the fill counts R and E, through the one read
//   port of each store scanned one entry a cycle
// reset: only the fill counts and control state are cleared; store contents
//   stay as they are and are never read above the counts (no clearing pass)
// stalls: one transaction is worked on at a time; a finished result sits in
//   the output register and the next transaction is taken while it waits
`default_nettype none

module set_intersection_unique_unit #(
  parameter int STORE_DEPTH = siu_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        func,
  input  wire logic signed [siu_pkg::ITEM_W-1:0] item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   emitted,
  output logic signed [siu_pkg::ITEM_W-1:0]      item_out,
  output logic                                   store_full
);
  import siu_pkg::*;

  // count width holds the depth itself; address width indexes one entry
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

  state_t state, state_next;

  logic [CNT_W-1:0] ref_count,  ref_count_next;
  logic [CNT_W-1:0] emit_count, emit_count_next;
  logic [CNT_W-1:0] idx,        idx_next;
  logic             rd_pending, rd_pending_next;
  logic             out_valid_next;

  // probed value and pending result, payload only
  logic [ITEM_W-1:0] probe,       probe_next;
  logic              res_emitted, res_emitted_next;
  logic [ITEM_W-1:0] res_item,    res_item_next;
  logic              res_full,    res_full_next;

  logic              in_accept;
  logic              out_free;
  logic              out_load;

  // memory ports
  logic              ref_we,  ref_re;
  logic              emit_we, emit_re;
  logic [ITEM_W-1:0] ref_rdata, emit_rdata;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  siu_ram #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ITEM_W)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_count[ADDR_W-1:0]),
    .wdata (item),
    .re    (ref_re),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (ref_rdata)
  );

  siu_ram #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ITEM_W)
  ) u_emit_ram (
    .clk   (clk),
    .we    (emit_we),
    .waddr (emit_count[ADDR_W-1:0]),
    .wdata (probe),
    .re    (emit_re),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (emit_rdata)
  );

  // next state, datapath updates and memory strobes
  always_comb begin
    state_next       = state;
    ref_count_next   = ref_count;
    emit_count_next  = emit_count;
    idx_next         = idx;
    rd_pending_next  = 1'b0;
    probe_next       = probe;
    res_emitted_next = res_emitted;
    res_item_next    = res_item;
    res_full_next    = res_full;
    ref_we           = 1'b0;
    ref_re           = 1'b0;
    emit_we          = 1'b0;
    emit_re          = 1'b0;
    out_load         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          res_emitted_next = 1'b0;
          res_item_next    = '0;
          res_full_next    = 1'b0;
          state_next       = ST_DONE;
          case (func)
            FUNC_CLEAR: begin
              ref_count_next  = '0;
              emit_count_next = '0;
            end
            FUNC_LOAD: begin
              if (ref_count < DEPTH_C) begin
                ref_we         = 1'b1;
                ref_count_next = ref_count + CNT_W'(1);
              end else begin
                res_full_next = 1'b1;
              end
            end
            FUNC_PROBE: begin
              probe_next = item;
              idx_next   = '0;
              state_next = ST_SCAN_REF;
            end
            default: begin
              // unused code: no state change, all-zero result
            end
          endcase
        end
      end

      // walk the reference store, one read issued per cycle
      ST_SCAN_REF: begin
        if (rd_pending && (ref_rdata == probe)) begin
          idx_next   = '0;
          state_next = ST_SCAN_EMIT;
        end else if (idx < ref_count) begin
          ref_re          = 1'b1;
          idx_next        = idx + CNT_W'(1);
          rd_pending_next = 1'b1;
        end else if (!rd_pending) begin
          // not in the reference list
          state_next = ST_DONE;
        end
      end

      // walk the emitted store; a miss records the value if the store has room
      ST_SCAN_EMIT: begin
        if (rd_pending && (emit_rdata == probe)) begin
          state_next = ST_DONE;
        end else if (idx < emit_count) begin
          emit_re         = 1'b1;
          idx_next        = idx + CNT_W'(1);
          rd_pending_next = 1'b1;
        end else if (!rd_pending) begin
          if (emit_count < DEPTH_C) begin
            emit_we          = 1'b1;
            emit_count_next  = emit_count + CNT_W'(1);
            res_emitted_next = 1'b1;
            res_item_next    = probe;
          end
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = out_load || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count  <= '0;
      emit_count <= '0;
      idx        <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      ref_count  <= ref_count_next;
      emit_count <= emit_count_next;
      idx        <= idx_next;
      rd_pending <= rd_pending_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    probe       <= probe_next;
    res_emitted <= res_emitted_next;
    res_item    <= res_item_next;
    res_full    <= res_full_next;
    if (out_load) begin
      emitted    <= res_emitted;
      item_out   <= res_item;
      store_full <= res_full;
    end
  end

  // fill counts stay within the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (ref_count <= DEPTH_C) && (emit_count <= DEPTH_C))
    else $error("fill count beyond store depth");

  // every emitted value is a distinct reference entry
  a_emit_le_ref: assert property (@(posedge clk) disable iff (rst)
    emit_count <= ref_count)
    else $error("emitted count exceeds reference count");

  // a result never reports both an emit and a dropped load
  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(emitted && store_full))
    else $error("emitted and store_full both set");

  // recording an emitted value bumps the emitted count by one
  a_emit_bump: assert property (@(posedge clk) disable iff (rst)
    emit_we |=> (emit_count == $past(emit_count) + CNT_W'(1)))
    else $error("emitted count not advanced on record");

endmodule

`default_nettype wire
